// File: sv/hkit_pkg.sv
// shared types and constants for the hashed key to id table
package hkit_pkg;

  localparam int KEY_W = 64;
  localparam int ID_W = 16;
  localparam int ENTRY_W = KEY_W + ID_W;
  localparam int TABLE_SLOTS_DEF = 256;

  // mixer constants
  localparam logic [63:0] MIX_GOLDEN = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_MUL1 = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_MUL2 = 64'h94D0_49BB_1331_11EB;
  localparam int MIX_SH0 = 30;
  localparam int MIX_SH1 = 27;
  localparam int MIX_SH2 = 31;

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  new_id;
  } cmd_t;

  typedef struct packed {
    logic [ID_W-1:0] result_id;
    logic            table_full;
  } res_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
  } slot_t;

endpackage

// File: sv/hkit_ram.sv
// generic single write port, single read port ram with registered read
module hkit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/hkit_hash.sv
// splitmix64 home slot hash on one shared 32x32 multiplier
module hkit_hash
  import hkit_pkg::*;
#(
  parameter int SLOT_W = $clog2(TABLE_SLOTS_DEF)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic [KEY_W-1:0]  key,
  output logic              done,
  output logic [SLOT_W-1:0] slot
);

  logic [63:0] a;
  logic [63:0] acc;
  logic [1:0]  part;
  logic        round;
  logic        active;

  logic [63:0] seed;
  logic [63:0] mul_b;
  logic [31:0] mul_x;
  logic [31:0] mul_y;
  logic [63:0] prod;
  logic [31:0] sum_hi;
  logic [63:0] full;
  logic [63:0] fin;

  assign seed = key + MIX_GOLDEN;
  assign mul_b = round ? MIX_MUL2 : MIX_MUL1;

  // low 64 bits of a * b from three partial products
  always_comb begin
    case (part)
      2'd0: begin
        mul_x = a[31:0];
        mul_y = mul_b[31:0];
      end
      2'd1: begin
        mul_x = a[31:0];
        mul_y = mul_b[63:32];
      end
      default: begin
        mul_x = a[63:32];
        mul_y = mul_b[31:0];
      end
    endcase
  end

  assign prod = 64'(mul_x) * 64'(mul_y);
  assign sum_hi = acc[63:32] + prod[31:0];
  assign full = {sum_hi, acc[31:0]};
  assign fin = full ^ (full >> MIX_SH2);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        a <= seed ^ (seed >> MIX_SH0);
        part <= 2'd0;
        round <= 1'b0;
        active <= 1'b1;
      end else if (active) begin
        case (part)
          2'd0: begin
            acc <= prod;
            part <= 2'd1;
          end
          2'd1: begin
            acc[63:32] <= sum_hi;
            part <= 2'd2;
          end
          default: begin
            if (!round) begin
              a <= full ^ (full >> MIX_SH1);
              round <= 1'b1;
              part <= 2'd0;
            end else begin
              active <= 1'b0;
              done <= 1'b1;
              slot <= fin[SLOT_W-1:0];
            end
          end
        endcase
      end
    end
  end

endmodule

// File: sv/hashed_key_to_id_table.sv
// key to id map: open addressing table with linear probing over one ram
// a result needs the hash and then P probes, P from 1 to TABLE_SLOTS
// the hash runs on one shared 32x32 multiplier; each probe is one ram read
// insert of key zero is answered on the next cycle; next item may start in the strobe cycle
// results cannot be held off: done marks one cycle of result
// after reset a clearing pass over all TABLE_SLOTS slots empties the ram, busy stays high
module hashed_key_to_id_table
  import hkit_pkg::*;
#(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  cmd_t cmd,
  output logic busy,
  output res_t result,
  output logic done
);

  localparam int SLOT_W = $clog2(TABLE_SLOTS);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_HASH  = 2'd2;
  localparam logic [1:0] ST_PROBE = 2'd3;

  logic [1:0]        state;
  logic [SLOT_W-1:0] clr_addr;
  logic [SLOT_W-1:0] pos;
  logic [SLOT_W-1:0] cnt;
  cmd_t              req;

  logic              hash_go;
  logic              hash_done;
  logic [SLOT_W-1:0] hash_slot;

  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [SLOT_W-1:0] ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  slot_t             slot_q;
  logic [SLOT_W-1:0] pos_inc;
  logic              empty;
  logic              hit;
  logic              last;

  assign busy = (state != ST_IDLE);
  assign hash_go = start && (state == ST_IDLE);

  hkit_hash #(
    .SLOT_W (SLOT_W)
  ) u_hash (
    .clk  (clk),
    .rst  (rst),
    .go   (hash_go),
    .key  (cmd.key),
    .done (hash_done),
    .slot (hash_slot)
  );

  hkit_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign slot_q = slot_t'(ram_rdata);
  assign pos_inc = pos + 1'b1;
  assign empty = (slot_q.key == '0);
  assign hit = (slot_q.key == req.key);
  assign last = (cnt == '1);

  // next slot is read ahead while the current one is checked
  assign ram_raddr = (state == ST_HASH) ? hash_slot : pos_inc;

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = pos;
    ram_wdata = {req.key, req.new_id};
    if (state == ST_CLEAR) begin
      ram_we = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (state == ST_PROBE && empty && req.mode == MODE_INSERT) begin
      ram_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            req <= cmd;
            if (cmd.mode == MODE_INSERT && cmd.key == '0) begin
              result <= '0;
              done <= 1'b1;
            end else begin
              state <= ST_HASH;
            end
          end
        end
        ST_HASH: begin
          if (hash_done) begin
            pos <= hash_slot;
            cnt <= '0;
            state <= ST_PROBE;
          end
        end
        ST_PROBE: begin
          if (empty) begin
            result <= '0;
            done <= 1'b1;
            state <= ST_IDLE;
          end else if (hit && req.mode == MODE_LOOKUP) begin
            result.result_id <= slot_q.id;
            result.table_full <= 1'b0;
            done <= 1'b1;
            state <= ST_IDLE;
          end else if (last) begin
            // every slot probed once
            result.result_id <= '0;
            result.table_full <= (req.mode == MODE_INSERT);
            done <= 1'b1;
            state <= ST_IDLE;
          end else begin
            pos <= pos_inc;
            cnt <= cnt + 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == ST_PROBE || $past(state) == ST_IDLE))
    else $error("result strobe from an unexpected state");

  a_full_insert: assert property (@(posedge clk) disable iff (rst)
    (done && result.table_full) |-> (req.mode == MODE_INSERT && result.result_id == '0))
    else $error("table full flagged on a lookup or with an id");

  a_we_state: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_CLEAR || state == ST_PROBE))
    else $error("ram written outside clearing or probing");

  a_hash_idle: assert property (@(posedge clk) disable iff (rst)
    hash_done |-> (state == ST_HASH || state == ST_IDLE))
    else $error("hash finished while not awaited");

endmodule
